[src/masked_radius_ring_search_macros.svh]
// ----------------------------------------------------------------------------
// Masked radius ring search: assertion macros
// Shared concurrent assertion forms used across the RTL.
// ----------------------------------------------------------------------------
`ifndef MASKED_RADIUS_RING_SEARCH_MACROS_SVH
`define MASKED_RADIUS_RING_SEARCH_MACROS_SVH

// condition holds at every edge out of reset
`define MRRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define MRRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[src/mrrs_pkg.sv]
// ----------------------------------------------------------------------------
// Masked radius ring search: package
// Beat types, queue sizing and ring constants.
// ----------------------------------------------------------------------------
package mrrs_pkg;

  localparam int RING_CAPACITY = 256;
  localparam logic [7:0] RING_LAST = 8'(RING_CAPACITY - 1);

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [31:0]        flags;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] value;
    logic               find_farthest;
    logic               is_last;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [7:0]         match_offset;
    logic signed [31:0] match_key;
  } out_beat_t;

  // classified beat passed from front to back
  typedef struct packed {
    logic               is_start;
    logic               last;
    logic               largest;
    logic               rad_neg;
    logic               hit;
    logic               in_rad;
    logic signed [31:0] key;
    logic [7:0]         offset;
  } q_item_t;

endpackage

[src/mrrs_queue.sv]
// ----------------------------------------------------------------------------
// Masked radius ring search: decoupling queue
// Small register FIFO between classifier front and selection back.
// ----------------------------------------------------------------------------
module mrrs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrrs_pkg::q_item_t wr_item,
  input  logic              pop,
  output mrrs_pkg::q_item_t rd_item,
  output logic              empty,
  output logic [mrrs_pkg::QCNT_W-1:0] count
);
  import mrrs_pkg::*;

  `include "masked_radius_ring_search_macros.svh"

  q_item_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_item = mem[rd_ptr_r];
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  `MRRS_ASSERT_ALWAYS(a_q_no_overflow, !(push && (cnt_r == QCNT_W'(QDEPTH)) && !pop), "queue overflow")
  `MRRS_ASSERT_ALWAYS(a_q_cnt_bound, cnt_r <= QCNT_W'(QDEPTH), "queue count out of range")
  `MRRS_ASSERT_NEXT(a_q_fill, push && !do_pop && (cnt_r != QCNT_W'(QDEPTH)), !empty, "push lost")

endmodule

[src/mrrs_front.sv]
// ----------------------------------------------------------------------------
// Masked radius ring search: front
// Takes beats, holds the query, tracks scan offset and runs the
// distance pipeline (difference, square, sum, compare).
// ----------------------------------------------------------------------------
module mrrs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  mrrs_pkg::in_beat_t in_data,
  output logic               q_push,
  output mrrs_pkg::q_item_t  q_item,
  input  logic [mrrs_pkg::QCNT_W-1:0] q_count
);
  import mrrs_pkg::*;

  logic               accept;
  logic [QCNT_W:0]    occ;

  logic [31:0]        mask_r;
  logic [31:0]        qp_r [3];
  logic [31:0]        rad_r;
  logic [61:0]        r2_r;
  logic [61:0]        r2_s2_r, r2_s3_r;
  logic [7:0]         scan_r;

  logic [31:0]        in_pos [3];
  logic [32:0]        diff [3];
  logic [32:0]        mag [3];

  logic               v1_r, v2_r, v3_r;
  q_item_t            s1_r, s2_r, s3_r;
  logic [32:0]        mag1_r [3];
  logic [64:0]        sq2_r [3];
  logic [66:0]        sum3_r;

  assign accept = in_push && !in_full;
  assign occ    = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v1_r)
                + (QCNT_W+1)'(v2_r) + (QCNT_W+1)'(v3_r);
  assign in_full = occ >= (QCNT_W+1)'(QDEPTH);

  assign in_pos[0] = in_data.pos_x;
  assign in_pos[1] = in_data.pos_y;
  assign in_pos[2] = in_data.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {in_pos[i][31], in_pos[i]} - {qp_r[i][31], qp_r[i]};
      mag[i]  = diff[i][32] ? (~diff[i] + 33'd1) : diff[i];
    end
  end

  // query and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      rad_r  <= '0;
      scan_r <= '0;
      for (int i = 0; i < 3; i++) begin
        qp_r[i] <= '0;
      end
    end else if (accept) begin
      if (in_data.cmd == CMD_START) begin
        mask_r  <= in_data.flags;
        rad_r   <= in_data.value;
        qp_r[0] <= in_data.pos_x;
        qp_r[1] <= in_data.pos_y;
        qp_r[2] <= in_data.pos_z;
        scan_r  <= '0;
      end else begin
        scan_r  <= (scan_r == RING_LAST) ? 8'd0 : scan_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= 62'(rad_r[30:0]) * 62'(rad_r[30:0]);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages; squared radius travels with its beat so a later start
  // cannot change it
  always_ff @(posedge clk) begin
    s1_r.is_start <= (in_data.cmd == CMD_START);
    s1_r.last     <= in_data.is_last;
    s1_r.largest  <= in_data.find_farthest;
    s1_r.rad_neg  <= in_data.value[31];
    s1_r.hit      <= |(in_data.flags & mask_r);
    s1_r.in_rad   <= 1'b0;
    s1_r.key      <= in_data.value;
    s1_r.offset   <= scan_r;
    for (int i = 0; i < 3; i++) begin
      mag1_r[i] <= mag[i];
      // magnitude reaches 2^32 only with all lower bits clear
      sq2_r[i]  <= mag1_r[i][32] ? {1'b1, 64'd0}
                                 : {1'b0, 64'(mag1_r[i][31:0]) * 64'(mag1_r[i][31:0])};
    end
    s2_r    <= s1_r;
    s3_r    <= s2_r;
    r2_s2_r <= r2_r;
    r2_s3_r <= r2_s2_r;
    sum3_r  <= 67'(sq2_r[0]) + 67'(sq2_r[1]) + 67'(sq2_r[2]);
  end

  always_comb begin
    q_push        = v3_r;
    q_item        = s3_r;
    q_item.in_rad = sum3_r < 67'(r2_s3_r);
  end

endmodule

[src/mrrs_back.sv]
// ----------------------------------------------------------------------------
// Masked radius ring search: back
// Serial best-match update and two-slot result buffer.
// ----------------------------------------------------------------------------
module mrrs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic signed [31:0]  cfg_data,
  input  logic                q_empty,
  input  mrrs_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output mrrs_pkg::out_beat_t out_data
);
  import mrrs_pkg::*;

  `include "masked_radius_ring_search_macros.svh"

  logic signed [31:0] init_key_r;
  logic               largest_r, largest_nxt;
  logic               rad_neg_r, rad_neg_nxt;
  logic               locked_r, locked_nxt;
  logic signed [31:0] best_key_r, best_key_nxt;
  logic [7:0]         best_off_r, best_off_nxt;
  logic               have_r, have_nxt;

  out_beat_t          ob_slot [2];
  logic               ob_wr_r, ob_rd_r;
  logic [1:0]         ob_cnt_r, ob_cnt_nxt;
  logic               emit, take, bigger, ob_pop;
  out_beat_t          beat;

  assign q_pop     = !q_empty && (ob_cnt_r != 2'd2);
  assign out_empty = (ob_cnt_r == 2'd0);
  assign out_data  = ob_slot[ob_rd_r];
  assign ob_pop    = out_pop && !out_empty;

  always_comb begin
    largest_nxt  = largest_r;
    rad_neg_nxt  = rad_neg_r;
    locked_nxt   = locked_r;
    best_key_nxt = best_key_r;
    best_off_nxt = best_off_r;
    have_nxt     = have_r;
    emit         = 1'b0;
    take         = 1'b0;
    bigger       = q_item.key > best_key_r;
    if (q_pop) begin
      emit = q_item.last;
      if (q_item.is_start) begin
        largest_nxt  = q_item.largest;
        rad_neg_nxt  = q_item.rad_neg;
        locked_nxt   = 1'b0;
        best_key_nxt = init_key_r;
        best_off_nxt = '0;
        have_nxt     = 1'b0;
      end else if (q_item.hit && !locked_r) begin
        if (rad_neg_r) begin
          take = largest_r ? bigger : 1'b1;
          if (!largest_r) begin
            locked_nxt = 1'b1;
          end
        end else begin
          take = (!largest_r || bigger) && q_item.in_rad;
        end
        if (take) begin
          best_key_nxt = q_item.key;
          best_off_nxt = q_item.offset;
          have_nxt     = 1'b1;
        end
      end
    end
    beat.found        = have_nxt;
    beat.match_offset = have_nxt ? best_off_nxt : 8'd0;
    beat.match_key    = best_key_nxt;
    ob_cnt_nxt        = ob_cnt_r + 2'(emit) - 2'(ob_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_key_r <= 32'sh8000_0000;
      largest_r  <= 1'b0;
      rad_neg_r  <= 1'b0;
      locked_r   <= 1'b0;
      best_key_r <= '0;
      best_off_r <= '0;
      have_r     <= 1'b0;
      ob_wr_r    <= 1'b0;
      ob_rd_r    <= 1'b0;
      ob_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        init_key_r <= cfg_data;
      end
      largest_r  <= largest_nxt;
      rad_neg_r  <= rad_neg_nxt;
      locked_r   <= locked_nxt;
      best_key_r <= best_key_nxt;
      best_off_r <= best_off_nxt;
      have_r     <= have_nxt;
      ob_wr_r    <= emit ? ~ob_wr_r : ob_wr_r;
      ob_rd_r    <= ob_pop ? ~ob_rd_r : ob_rd_r;
      ob_cnt_r   <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_slot[ob_wr_r] <= beat;
    end
  end

  `MRRS_ASSERT_ALWAYS(a_ob_bound, ob_cnt_r != 2'd3, "result buffer overrun")
  `MRRS_ASSERT_ALWAYS(a_lock_mode, !(locked_r && largest_r), "lock in largest-key mode")
  `MRRS_ASSERT_NEXT(a_emit_seen, emit && !ob_pop, !out_empty, "result beat lost")

endmodule

[src/masked_radius_ring_search.sv]
// ----------------------------------------------------------------------------
// Masked radius ring search: top level
// A start beat loads a flagged 3D query; entry beats stream in oldest first
// and the beat marked last yields found, offset and key of the selection.
//
// Input: push in_data while in_full is low. Start beats (cmd 0) load mask,
//   point, radius and mode; entry beats (cmd 1) are tested against them.
// Results: while out_empty is low the oldest result sits on out_data and
//   leaves on out_pop. Only beats with is_last set produce a result.
// Config: cfg_we writes cfg_data as the starting best key (reset -2^31);
//   write it only while the block is idle.
// Throughput: one beat per cycle while in_full is low, set by the best-key update.
// Path: an accepted last beat passes the three-stage distance pipeline,
//   the queue and the result buffer before it shows on out_data.
// Stall: with out_pop low the two-slot result buffer fills, then the queue
//   and distance pipeline (eight beats between them), then in_full rises;
//   nothing is dropped.
// Reset: synchronous, active low; queues empty, query cleared, no result.
// ----------------------------------------------------------------------------
module masked_radius_ring_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  mrrs_pkg::in_beat_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output mrrs_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic signed [31:0]  cfg_data
);
  import mrrs_pkg::*;

  logic              q_push, q_pop, q_empty;
  q_item_t           q_wr_item, q_rd_item;
  logic [QCNT_W-1:0] q_count;

  mrrs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_item  (q_wr_item),
    .q_count (q_count)
  );

  mrrs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty),
    .count   (q_count)
  );

  mrrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Masked radius ring search: testbench
// Directed and random start/entry beats are pushed through the input queue
// under sender idling and receiver stalls. An in-bench search predictor
// tracks query, best key and scan offset, and each result beat is checked
// against the oldest prediction. The starting best key is rewritten
// between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mrrs_pkg::*;

  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_beat_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic signed [31:0] cfg_data = '0;

  masked_radius_ring_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // search predictor state
  logic signed [31:0] start_key = KEY_MIN;
  logic [31:0] srch_mask = '0;
  logic [31:0] srch_pt [3] = '{default: '0};
  logic [31:0] srch_radius = '0;
  bit srch_largest = 1'b0;
  bit srch_locked = 1'b0;
  logic signed [31:0] srch_best = '0;
  logic [7:0] srch_best_off = '0;
  bit srch_have = 1'b0;
  logic [7:0] srch_scan = '0;

  out_beat_t pending_results[$];
  int mismatches = 0;
  int beats_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int idle_cycles = 0;

  function automatic bit within_radius(input in_beat_t b);
    logic [31:0] p [3];
    logic [32:0] d, m;
    logic [63:0] sq, r;
    logic [65:0] acc;
    int i;
    p[0] = b.pos_x;
    p[1] = b.pos_y;
    p[2] = b.pos_z;
    acc = '0;
    for (i = 0; i < 3; i++) begin
      d = {p[i][31], p[i]} - {srch_pt[i][31], srch_pt[i]};
      m = d[32] ? -d : d;
      sq = {31'b0, m} * {31'b0, m};
      acc = acc + {2'b00, sq};
    end
    r = {32'b0, srch_radius};
    return (acc[65:64] == 2'b00) && (acc[63:0] < r * r);
  endfunction

  function automatic bit search_step(input in_beat_t b, output out_beat_t r);
    logic signed [31:0] key;
    bit bigger, take;
    key = b.value;
    r = '0;
    if (b.cmd == CMD_START) begin
      srch_mask = b.flags;
      srch_pt[0] = b.pos_x;
      srch_pt[1] = b.pos_y;
      srch_pt[2] = b.pos_z;
      srch_radius = b.value;
      srch_largest = b.find_farthest;
      srch_locked = 1'b0;
      srch_best = start_key;
      srch_best_off = '0;
      srch_have = 1'b0;
      srch_scan = '0;
    end else begin
      if ((b.flags & srch_mask) != '0 && !srch_locked) begin
        bigger = key > srch_best;
        if (srch_radius[31]) begin
          take = srch_largest ? bigger : 1'b1;
          if (!srch_largest) srch_locked = 1'b1;
        end else begin
          take = (!srch_largest || bigger) && within_radius(b);
        end
        if (take) begin
          srch_best = key;
          srch_best_off = srch_scan;
          srch_have = 1'b1;
        end
      end
      srch_scan = (srch_scan == RING_LAST) ? 8'd0 : srch_scan + 8'd1;
    end
    if (b.is_last) begin
      r.found = srch_have;
      r.match_offset = srch_have ? srch_best_off : 8'd0;
      r.match_key = srch_best;
    end
    return b.is_last;
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void check_result(input out_beat_t got);
    out_beat_t want;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("unexpected result beat: found %0d offset %0d key %0d",
                             got.found, got.match_offset, got.match_key));
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found || got.match_offset !== want.match_offset ||
        got.match_key !== want.match_key)
      note_failure($sformatf("result mismatch: exp found %0d offset %0d key %0d, got found %0d offset %0d key %0d",
                             want.found, want.match_offset, want.match_key,
                             got.found, got.match_offset, got.match_key));
  endfunction

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_result(out_data);
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("masked_radius_ring_search test failed");
        $finish;
      end
    end
  end

  function automatic in_beat_t make_start(input logic [31:0] mask, x, y, z, radius,
                                          input bit largest, input bit last);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_START;
    b.flags = mask;
    b.pos_x = x;
    b.pos_y = y;
    b.pos_z = z;
    b.value = radius;
    b.find_farthest = largest;
    b.is_last = last;
    return b;
  endfunction

  function automatic in_beat_t make_entry(input logic [31:0] flags, x, y, z, key,
                                          input bit last);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_ENTRY;
    b.flags = flags;
    b.pos_x = x;
    b.pos_y = y;
    b.pos_z = z;
    b.value = key;
    b.find_farthest = $urandom_range(1);
    b.is_last = last;
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b);
    out_beat_t r;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_push <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_full);
    beats_sent++;
    if (search_step(b, r)) pending_results.push_back(r);
  endtask

  // sender pause: drain every pending result, then let the pipe empty
  task automatic settle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_key(input logic [31:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_key = v;
  endtask

  task automatic test_entries_before_start();
    send_beat(make_entry(ALL_ONES, 0, 0, 0, 32'd7, 1'b0));
    send_beat(make_entry(ALL_ONES, 0, 0, 0, 32'd9, 1'b1));
  endtask

  task automatic test_empty_ring();
    write_start_key(32'h1234_5678);
    send_beat(make_start(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b1));
    write_start_key(KEY_MIN);
    send_beat(make_start('0, KEY_MIN, KEY_MAX, 0, KEY_MAX, 1'b0, 1'b1));
  endtask

  task automatic test_first_match_open();
    send_beat(make_start(32'h0000_0001, 0, 0, 0, ALL_ONES, 1'b0, 1'b0));
    send_beat(make_entry(32'h0000_0002, 0, 0, 0, 32'd3, 1'b0));
    send_beat(make_entry(32'h8000_0001, KEY_MAX, KEY_MIN, 0, 32'd5, 1'b0));
    send_beat(make_entry(32'h0000_0001, 0, 0, 0, 32'd100, 1'b1));
  endtask

  task automatic test_largest_key();
    send_beat(make_start(ALL_ONES, 0, 0, 0, KEY_MIN, 1'b1, 1'b0));
    send_beat(make_entry(32'h0000_0010, 0, 0, 0, KEY_MIN, 1'b0));
    send_beat(make_entry(32'h0000_0010, 0, 0, 0, 32'd10, 1'b0));
    send_beat(make_entry(32'h0000_0100, 0, 0, 0, 32'd10, 1'b0));
    send_beat(make_entry(32'h0000_0001, 0, 0, 0, -32'sd5, 1'b0));
    send_beat(make_entry(32'h4000_0000, 0, 0, 0, KEY_MAX, 1'b1));
  endtask

  task automatic test_radius_and_continuation();
    send_beat(make_start(32'h0000_00F0, 0, 0, 0, 32'h100, 1'b0, 1'b0));
    send_beat(make_entry(32'h0000_0010, 32'hFF, 0, 0, 32'd1, 1'b0));
    send_beat(make_entry(32'h0000_0010, 32'h100, 0, 0, 32'd2, 1'b0));
    send_beat(make_entry(32'h0000_0001, 32'h10, 32'h10, 32'h10, 32'd3, 1'b0));
    send_beat(make_entry(32'h0000_0080, -32'sh10, 32'h10, -32'sh10, 32'd4, 1'b1));
    send_beat(make_entry(32'h0000_0020, 0, 0, 0, 32'd9, 1'b1));
  endtask

  task automatic test_zero_radius_and_overflow();
    send_beat(make_start(ALL_ONES, 32'h55, 32'h66, 32'h77, 0, 1'b0, 1'b0));
    send_beat(make_entry(ALL_ONES, 32'h55, 32'h66, 32'h77, 32'd1, 1'b1));
    send_beat(make_start(ALL_ONES, KEY_MIN, KEY_MIN, KEY_MIN, KEY_MAX, 1'b1, 1'b0));
    send_beat(make_entry(ALL_ONES, KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, 1'b1));
  endtask

  // hold the result side off so the input queue fills and stalls
  task automatic test_backpressure();
    int i;
    settle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 300;
    for (i = 0; i < 30; i++)
      send_beat(make_start($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(1), 1'b1));
    send_beat(make_start(ALL_ONES, 0, 0, 0, ALL_ONES, 1'b1, 1'b0));
    for (i = 0; i < 6; i++)
      send_beat(make_entry($urandom, 0, 0, 0, $urandom, i == 5));
    settle();
  endtask

  function automatic logic [31:0] rand_point();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 32'($urandom_range(32'hFFFF)) - 32'h8000;
    if (roll < 85) return $urandom;
    return $urandom_range(1) ? KEY_MIN : KEY_MAX;
  endfunction

  function automatic logic [31:0] rand_near(input logic [31:0] c);
    if ($urandom_range(99) < 75) return c + 32'($urandom_range(32'h2000)) - 32'h1000;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return 32'($urandom_range(16)) - 32'd8;
    if (roll < 85) return $urandom;
    return $urandom_range(1) ? KEY_MIN : KEY_MAX;
  endfunction

  function automatic logic [31:0] rand_radius();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return {1'b1, 31'($urandom)};
    if (roll < 35) return '0;
    if (roll < 85) return $urandom_range(32'h2000, 1);
    if (roll < 95) return $urandom_range(KEY_MAX);
    return KEY_MAX;
  endfunction

  function automatic logic [31:0] rand_mask();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom;
    if (roll < 70) return 32'h1 << $urandom_range(31);
    if (roll < 85) return $urandom & $urandom;
    if (roll < 95) return ALL_ONES;
    return '0;
  endfunction

  function automatic logic [31:0] rand_flags(input logic [31:0] mask);
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom;
    if (roll < 70) return $urandom & mask;
    if (roll < 85) return 32'h1 << $urandom_range(31);
    return $urandom_range(1) ? '0 : ~mask;
  endfunction

  task automatic send_ring(input int len, input logic [31:0] mask, x, y, z);
    int i;
    for (i = 0; i < len; i++)
      send_beat(make_entry(rand_flags(mask), rand_near(x), rand_near(y), rand_near(z),
                           rand_key(), i == len - 1));
  endtask

  task automatic run_traffic(input int n_beats);
    int target, roll, len;
    logic [31:0] mask, x, y, z;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 85) begin
        mask = rand_mask();
        x = rand_point();
        y = rand_point();
        z = rand_point();
        len = $urandom_range(99);
        if (len < 5) len = 0;
        else if (len < 93) len = $urandom_range(12, 1);
        else if (len < 98) len = $urandom_range(40, 13);
        else len = $urandom_range(300, 250);
        send_beat(make_start(mask, x, y, z, rand_radius(), $urandom_range(1), len == 0));
        if (len != 0) begin
          send_ring(len, mask, x, y, z);
          if ($urandom_range(99) < 10) send_ring($urandom_range(6, 1), mask, x, y, z);
        end
      end else if (roll < 95) begin
        send_beat(make_entry($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(3) == 0));
      end else begin
        send_beat(make_start($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(1), $urandom_range(1)));
      end
    end
  endtask

  task automatic test_traffic_phases();
    write_start_key(KEY_MAX);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_traffic(430);
    write_start_key(32'd0);
    tx_idle_pct = 64;
    rx_stall_pct = 0;
    run_traffic(430);
    write_start_key($urandom);
    tx_idle_pct = 0;
    rx_stall_pct = 64;
    run_traffic(430);
    write_start_key(KEY_MIN);
    tx_idle_pct = 28;
    rx_stall_pct = 28;
    run_traffic(430);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_entries_before_start();
    test_empty_ring();
    test_first_match_open();
    test_largest_key();
    test_radius_and_continuation();
    test_zero_radius_and_overflow();
    test_backpressure();
    test_traffic_phases();
    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("masked_radius_ring_search test passed");
    end else begin
      $display("masked_radius_ring_search test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/mrrs_pkg.sv
src/mrrs_queue.sv
src/mrrs_front.sv
src/mrrs_back.sv
src/masked_radius_ring_search.sv
tb/sv/tb_top.sv
